### src/mbd_pkg.sv
package mbd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned FIELD_BUTTONS = 8;
  localparam int unsigned BTN_W         = 3;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned S_DATA_W      = 16;
  localparam int unsigned M_DATA_W      = 16;

  localparam int unsigned NUM_BUTTONS_DEF = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd5;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL_HIGH = 1'b1;

  // tuser kind codes
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

### src/multi_button_debouncer_top.sv
// Debouncer for up to eight buttons sharing one block. Each transaction on the
// input stream is either an edge event (tuser 0) for one button or a periodic
// tick (tuser 1). An edge clears the button's tick count and, if the button was
// idle, makes it pending with the sampled level latched as target and as
// current level. On a tick every pending button whose count has reached
// debounce_ticks leaves pending and reports a rise or fall if its live pin
// matches the target; the others count on. One compare/increment unit walks the
// buttons one per cycle. An edge is handled as it is accepted; a tick is
// accepted, then scans N = min(NUM_BUTTONS, 8) buttons, then sends one empty
// result when nothing is reported, or walks the buttons up to and including the
// highest reporting one. Output stalls hold this walk, and no new transaction
// is taken meanwhile. Each tick or edge yields at least one result; reports
// come out in ascending button order with tlast on the final one.
// idle_level_high is write-accepted but ignored; the levels always reset high.
module multi_button_debouncer_top #(
  parameter int unsigned NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mbd_pkg::S_DATA_W-1:0]    s_tdata,  // button_index[2:0], edge_level[3],
                                                    // pin_levels[11:4], zero fill
  input  logic                            s_tuser,  // func
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mbd_pkg::M_DATA_W-1:0]    m_tdata,  // event_valid[0], event_button[3:1],
                                                    // event_rising[4], current_levels[12:5],
                                                    // zero fill
  output logic                            m_tlast,  // last_result
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned ACTIVE = (NUM_BUTTONS < mbd_pkg::FIELD_BUTTONS) ?
                                   NUM_BUTTONS : mbd_pkg::FIELD_BUTTONS;
  localparam int unsigned IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int unsigned CNT_W  = mbd_pkg::CNT_W;

  mbd_pkg::state_t state;

  logic [CNT_W-1:0]                 debounce_ticks;
  logic [ACTIVE-1:0]                pending_flags;
  logic [ACTIVE-1:0]                target_levels;
  logic [mbd_pkg::FIELD_BUTTONS-1:0] level_bits;
  logic [CNT_W-1:0]                 tick_counts [ACTIVE];
  logic [ACTIVE-1:0]                pins;
  logic [ACTIVE-1:0]                rep_mask;
  logic [IDX_W-1:0]                 idx;

  // input fields
  logic [mbd_pkg::BTN_W-1:0] in_btn;
  logic                      in_lvl;
  logic                      in_accept;
  logic                      out_free;
  logic                      btn_ok;
  logic [IDX_W-1:0]          btn_idx;
  logic                      idx_last;
  logic                      cnt_done;
  logic [ACTIVE-1:0]         rep_rest;

  // result to load into the output register this cycle
  logic                         out_load;
  logic                         out_last;
  logic [mbd_pkg::M_DATA_W-1:0] out_data;

  assign in_btn    = s_tdata[mbd_pkg::BTN_W-1:0];
  assign in_lvl    = s_tdata[mbd_pkg::BTN_W];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == mbd_pkg::ST_IDLE) && out_free;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign btn_ok   = ({29'd0, in_btn} < ACTIVE);
  assign btn_idx  = in_btn[IDX_W-1:0];
  assign idx_last = (idx == IDX_W'(ACTIVE - 1));

  // shared compare unit
  assign cnt_done = (tick_counts[idx] >= debounce_ticks);
  // reports still to go after the current one
  assign rep_rest = rep_mask & ~(ACTIVE'(1) << idx);

  always_comb begin
    out_load       = 1'b0;
    out_last       = 1'b1;
    out_data       = '0;
    out_data[12:5] = level_bits;
    unique case (state)
      mbd_pkg::ST_IDLE: begin
        if (in_accept && (s_tuser == mbd_pkg::FUNC_EDGE)) begin
          // edge: single empty result, level update visible
          out_load = 1'b1;
          if (btn_ok && !pending_flags[btn_idx]) begin
            out_data[12:5] = (level_bits & ~(8'd1 << in_btn)) |
                             ({7'd0, in_lvl} << in_btn);
          end
        end
      end
      mbd_pkg::ST_SCAN: ;
      mbd_pkg::ST_EMIT: begin
        if (rep_mask == '0) begin
          // tick with no report
          out_load = out_free;
        end else if (rep_mask[idx] && out_free) begin
          out_load     = 1'b1;
          out_last     = (rep_rest == '0);
          out_data[0]  = 1'b1;
          out_data[3:1] = mbd_pkg::BTN_W'(idx);
          out_data[4]  = target_levels[idx];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mbd_pkg::ST_IDLE;
      debounce_ticks <= mbd_pkg::DEBOUNCE_RST;
      pending_flags  <= '0;
      target_levels  <= '0;
      level_bits     <= '1;
      rep_mask       <= '0;
      idx            <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < ACTIVE; i++) begin
        tick_counts[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= out_data;
        m_tlast  <= out_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbd_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
          mbd_pkg::REG_IDLE_LEVEL_HIGH: ;  // write is accepted but ignored
          default: ;
        endcase
      end

      unique case (state)
        mbd_pkg::ST_IDLE: begin
          if (in_accept) begin
            if (s_tuser == mbd_pkg::FUNC_EDGE) begin
              if (btn_ok) begin
                tick_counts[btn_idx] <= '0;
                if (!pending_flags[btn_idx]) begin
                  pending_flags[btn_idx] <= 1'b1;
                  target_levels[btn_idx] <= in_lvl;
                  level_bits[in_btn]     <= in_lvl;
                end
              end
            end else begin
              pins     <= s_tdata[mbd_pkg::BTN_W+1 +: ACTIVE];
              rep_mask <= '0;
              idx      <= '0;
              state    <= mbd_pkg::ST_SCAN;
            end
          end
        end

        mbd_pkg::ST_SCAN: begin
          if (pending_flags[idx]) begin
            if (cnt_done) begin
              pending_flags[idx] <= 1'b0;
              if (pins[idx] == target_levels[idx]) begin
                rep_mask[idx] <= 1'b1;
              end
            end else begin
              tick_counts[idx] <= tick_counts[idx] + CNT_W'(1);
            end
          end
          if (idx_last) begin
            idx   <= '0;
            state <= mbd_pkg::ST_EMIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        mbd_pkg::ST_EMIT: begin
          if (rep_mask == '0) begin
            if (out_free) begin
              state <= mbd_pkg::ST_IDLE;
            end
          end else if (!rep_mask[idx]) begin
            idx <= idx + IDX_W'(1);
          end else if (out_free) begin
            rep_mask[idx] <= 1'b0;
            if (rep_rest == '0) begin
              state <= mbd_pkg::ST_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end

        default: state <= mbd_pkg::ST_IDLE;
      endcase
    end
  end

  // Input is only taken with the sequencer at rest
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == mbd_pkg::ST_IDLE))
    else $error("input taken while sequencer busy");

  // A button cannot be both pending and awaiting its report
  a_mask_disjoint: assert property (@(posedge clk) disable iff (rst)
    (pending_flags & rep_mask) == '0)
    else $error("reported button still pending");

  // An empty result is always the only one for its transaction
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> m_tlast)
    else $error("empty result without tlast");

  // Reports are all gone by the time the sequencer rests
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == mbd_pkg::ST_IDLE) |-> (rep_mask == '0))
    else $error("reports left behind");

endmodule

### bench/testbench.sv
module testbench;

  // One expected result transaction, fields as they leave the block
  typedef struct packed {
    logic       valid;
    logic [2:0] button;
    logic       rising;
    logic [7:0] levels;
    logic       last;
  } debounce_result_t;

  // Keeps its own copy of the debouncer state, predicts the results of each
  // accepted transaction and checks the result stream against them in order.
  class debounce_scoreboard;
    logic [7:0]       threshold;
    logic             idle_high;
    logic [7:0]       pending;
    logic [7:0]       target;
    logic [7:0]       levels;
    logic [7:0]       counts [8];
    debounce_result_t awaited [$];
    int unsigned      errors;
    int unsigned      reports;

    function new();
      threshold = mbd_pkg::DEBOUNCE_RST;
      idle_high = 1'b1;
      pending   = '0;
      target    = '0;
      levels    = 8'hFF;  // idle level at reset is high
      foreach (counts[i]) counts[i] = '0;
      errors    = 0;
      reports   = 0;
    endfunction

    // idle_high is never used: the block ignores it, and reset happens once
    function void write_register(logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                                 logic [mbd_pkg::CFG_DATA_W-1:0] data);
      if (idx == mbd_pkg::REG_DEBOUNCE_TICKS)
        threshold = data;
      else if (idx == mbd_pkg::REG_IDLE_LEVEL_HIGH)
        idle_high = data[0];
    endfunction

    function void take_item(logic func, logic [2:0] btn, logic lvl, logic [7:0] pins);
      debounce_result_t r;
      logic [7:0]       fired;
      int               total;
      int               n;
      fired = '0;
      total = 0;
      n     = 0;
      if (func == mbd_pkg::FUNC_EDGE) begin
        counts[btn] = '0;
        if (!pending[btn]) begin
          pending[btn] = 1'b1;
          target[btn]  = lvl;
          levels[btn]  = lvl;
        end
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (pending[i]) begin
            if (counts[i] >= threshold) begin
              pending[i] = 1'b0;
              if (pins[i] == target[i]) begin
                fired[i] = 1'b1;
                total++;
              end
            end else begin
              counts[i] = counts[i] + 8'd1;
            end
          end
        end
      end
      if (total == 0) begin
        r = '{valid: 1'b0, button: 3'd0, rising: 1'b0, levels: levels, last: 1'b1};
        awaited.push_back(r);
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (fired[i]) begin
            n++;
            r = '{valid: 1'b1, button: i[2:0], rising: target[i], levels: levels,
                  last: (n == total)};
            awaited.push_back(r);
            reports++;
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [mbd_pkg::M_DATA_W-1:0] data, logic last);
      debounce_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                 $time, data, last);
        errors++;
      end else begin
        r = awaited.pop_front();
        compare_field("event_valid", 8'(r.valid), 8'(data[0]));
        compare_field("event_button", 8'(r.button), 8'(data[3:1]));
        compare_field("event_rising", 8'(r.rising), 8'(data[4]));
        compare_field("current_levels", r.levels, data[12:5]);
        compare_field("fill bits", 8'd0, 8'(data[15:13]));
        compare_field("last_result", 8'(r.last), 8'(last));
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mbd_pkg::S_DATA_W-1:0]   s_tdata = '0;   // button_index[2:0], edge_level[3],
                                                  // pin_levels[11:4]
  logic                           s_tuser = 1'b0; // func
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mbd_pkg::M_DATA_W-1:0]   m_tdata;        // event_valid[0], event_button[3:1],
                                                  // event_rising[4], current_levels[12:5]
  logic                           m_tlast;        // last_result
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  debounce_scoreboard book;

  // Idle odds in percent per cycle, changed between phases
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  // Set by the stimulus to make the sink hold off for a long stretch
  logic        long_hold_req = 1'b0;
  // What the bench believes the pins are doing, so that most ticks match
  logic [7:0]  pin_state = 8'hFF;

  multi_button_debouncer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor: everything is sampled at the rising edge before the NBA region,
  // so driver and DUT updates of this edge are never seen here.
  // The input is booked before the output is checked, so a same-edge result
  // always finds its expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        book.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        book.take_item(s_tuser, s_tdata[2:0], s_tdata[3], s_tdata[11:4]);
      if (m_tvalid && m_tready)
        book.check_result(m_tdata, m_tlast);
    end
  end

  // Sink: random back-pressure, plus one long hold-off on request.
  // The hold is counted here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offers one transaction and returns at the edge it is taken.
  // tvalid stays high on return, so a following item does not toggle it
  // within one time step.
  task automatic send_item(input logic func, input logic [2:0] btn, input logic lvl,
                           input logic [7:0] pins);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, pins, lvl, btn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sender pauses until every expected result is in, then lets the block settle.
  // The first edge gives the monitor time to book the last transaction.
  task automatic wait_for_results(input int unsigned settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mbd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly plausible button activity: presses, bounce bursts and ticks whose
  // pins follow the last press, with the odd glitch and some pure noise.
  task automatic random_items(input int unsigned count, input int unsigned min_reports);
    int unsigned sent;
    int unsigned r;
    int unsigned burst;
    logic [2:0]  b;
    logic        l;
    logic [7:0]  glitch;
    sent = 0;
    while ((sent < count || book.reports < min_reports) && sent < 1500) begin
      r = $urandom_range(99);
      if (r < 30) begin
        b = 3'($urandom_range(7));
        l = 1'($urandom_range(1));
        pin_state[b] = l;
        send_item(mbd_pkg::FUNC_EDGE, b, l, 8'($urandom_range(255)));
        sent++;
      end else if (r < 40) begin
        // contact bounce: alternating edges on one button
        b     = 3'($urandom_range(7));
        l     = 1'($urandom_range(1));
        burst = $urandom_range(2, 4);
        for (int k = 0; k < burst; k++) begin
          send_item(mbd_pkg::FUNC_EDGE, b, l, 8'($urandom_range(255)));
          pin_state[b] = l;
          l = ~l;
          sent++;
        end
      end else if (r < 47) begin
        send_item(mbd_pkg::FUNC_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
        sent++;
      end else begin
        glitch = ($urandom_range(9) == 0) ? (8'd1 << $urandom_range(7)) : 8'd0;
        send_item(mbd_pkg::FUNC_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)),
                  pin_state ^ glitch);
        sent++;
      end
    end
  endtask

  initial begin
    book = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 11;
    sink_idle_pct = 60;

    // Directed part, defaults after reset: threshold 5, all levels high.
    // Clearing the idle level must not touch the levels before another reset.
    write_register(mbd_pkg::REG_IDLE_LEVEL_HIGH, 8'h00);
    send_item(mbd_pkg::FUNC_TICK, 3'd7, 1'b1, 8'h00);   // nothing pending, empty result
    send_item(mbd_pkg::FUNC_EDGE, 3'd0, 1'b0, 8'hFF);   // button 0 goes pending low
    send_item(mbd_pkg::FUNC_EDGE, 3'd7, 1'b1, 8'h00);   // button 7 goes pending high
    send_item(mbd_pkg::FUNC_EDGE, 3'd0, 1'b1, 8'h5A);   // bounce: count restarts
    // five ticks count up, the sixth reports a fall on 0 and a rise on 7
    repeat (6) send_item(mbd_pkg::FUNC_TICK, 3'd0, 1'b0, 8'h80);
    send_item(mbd_pkg::FUNC_EDGE, 3'd3, 1'b1, 8'h00);
    send_item(mbd_pkg::FUNC_EDGE, 3'd5, 1'b0, 8'h00);
    wait_for_results(12);
    // zero threshold: checked on the very next tick; pin 3 disagrees, so
    // button 3 drops out silently while button 5 reports
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'h00);
    send_item(mbd_pkg::FUNC_TICK, 3'd2, 1'b1, 8'h00);
    // every button at once: eight reports from one tick
    for (int k = 0; k < 8; k++)
      send_item(mbd_pkg::FUNC_EDGE, k[2:0], 1'(8'hA5 >> k), 8'h00);
    send_item(mbd_pkg::FUNC_TICK, 3'd5, 1'b0, 8'hA5);
    pin_state = 8'hA5;
    wait_for_results(12);

    // Random phase one: sender idles a little, receiver a lot, with one long
    // hold-off so the block backs up and stalls its input.
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'd2);
    write_register(mbd_pkg::REG_IDLE_LEVEL_HIGH, 8'h01);
    long_hold_req = 1'b1;
    random_items(80, 0);
    wait_for_results(12);

    // Maximum threshold: buttons stay pending and only count
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'hFF);
    random_items(20, 0);
    wait_for_results(12);

    // Random phase two, idling swapped. Dropping to zero lets the buttons
    // left pending above, with counts past the threshold, resolve at once.
    src_idle_pct  = 60;
    sink_idle_pct = 11;
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'h00);
    random_items(40, 0);
    wait_for_results(12);
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'h01);
    random_items(40, 0);
    wait_for_results(12);

    // Random phase three, full rate; runs on until enough reports were seen
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_register(mbd_pkg::REG_DEBOUNCE_TICKS, 8'($urandom_range(1, 4)));
    random_items(80, 48);
    wait_for_results(20);

    if (book.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
src/mbd_pkg.sv
src/multi_button_debouncer_top.sv
bench/testbench.sv
